### hdl/assert_macros.svh
// Assertion macros used by the queue (eqr_fifo) of the ray direction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hdl/eqr_pkg.sv
// Shared constants, types and functions of the equirectangular ray direction block.
package eqr_pkg;

	localparam int FRAC_BITS       = 14;
	localparam int PIXEL_FRAC_BITS = 4;
	localparam int MAX_RES         = 8192;

	// fixed field widths
	localparam int PIX_W     = 18;
	localparam int CFG_RES_W = 14;
	localparam int AXIS_W    = 48;
	localparam int COMP_W    = 16;
	localparam int CFG_W     = 48;
	localparam int ADDR_W    = 3;

	// register indexes
	localparam logic [ADDR_W-1:0] REG_RES_WIDTH    = 3'd0;
	localparam logic [ADDR_W-1:0] REG_RES_HEIGHT   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_AXIS_FORWARD = 3'd2;
	localparam logic [ADDR_W-1:0] REG_AXIS_RIGHT   = 3'd3;
	localparam logic [ADDR_W-1:0] REG_AXIS_UP      = 3'd4;

	// divider geometry
	localparam int RES_W = $clog2(MAX_RES + 1);
	localparam int DEN_W = RES_W + PIXEL_FRAC_BITS;
	localparam int NUM_W = PIX_W + FRAC_BITS + 2;
	localparam int PH_W  = FRAC_BITS + 2;

	// sine polynomial in Q30
	localparam int Q      = 30;
	localparam int SIN_SH = Q - FRAC_BITS;
	localparam int X_W    = Q + 1;
	localparam int T_W    = 31;
	localparam int S_W    = 32;
	localparam int SIN_W  = FRAC_BITS + 2;
	localparam logic [T_W-1:0] SIN_C1 = 31'd1686629713;
	localparam logic [T_W-1:0] SIN_C3 = 31'd693598668;
	localparam logic [T_W-1:0] SIN_C5 = 31'd85569306;
	localparam logic [T_W-1:0] SIN_C7 = 31'd5026996;
	localparam logic [T_W-1:0] SIN_C9 = 31'd172271;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [PH_W-1:0] ph_phi;
		logic [PH_W-1:0] ph_theta;
	} phase_t;

	// Map a resolution register onto 1..MAX_RES.
	function automatic logic [RES_W-1:0] clamp_res(input logic [CFG_RES_W-1:0] r);
		if (r == '0)
			return RES_W'(1);
		if (32'(r) > 32'(MAX_RES))
			return RES_W'(MAX_RES);
		return RES_W'(r);
	endfunction

endpackage

### hdl/eqr_front.sv
// Front part: pixel intake, pipelined position divider and phase forming.
module eqr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [eqr_pkg::PIX_W-1:0]   px,
	input  logic [eqr_pkg::PIX_W-1:0]   py,
	input  logic [eqr_pkg::RES_W-1:0]   res_w,
	input  logic [eqr_pkg::RES_W-1:0]   res_h,
	output logic                        push,
	output eqr_pkg::phase_t             push_data,
	input  logic                        full
);
	import eqr_pkg::*;

	typedef struct packed {
		logic [NUM_W-1:0] n;
		logic [DEN_W-1:0] r;
		logic [PH_W-1:0]  q;
	} div_t;

	// One restoring division step: bring down one numerator bit.
	function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] sh;
		div_t o;
		sh = {s.r, s.n[NUM_W-1]};
		o.n = {s.n[NUM_W-2:0], 1'b0};
		if (sh >= {1'b0, den}) begin
			o.r = DEN_W'(sh - {1'b0, den});
			o.q = {s.q[PH_W-2:0], 1'b1};
		end else begin
			o.r = DEN_W'(sh);
			o.q = {s.q[PH_W-2:0], 1'b0};
		end
		return o;
	endfunction

	logic [DEN_W-1:0] den_x, den_y;
	logic             en;
	div_t             dx_s [0:NUM_W];
	div_t             dy_s [0:NUM_W];
	logic             v_s  [0:NUM_W];

	assign den_x = DEN_W'(res_w) << PIXEL_FRAC_BITS;
	assign den_y = DEN_W'(res_h) << PIXEL_FRAC_BITS;

	// advance the whole pipe unless the last stage is stuck on a full queue
	assign en       = !v_s[NUM_W] || !full;
	assign in_ready = en;
	assign push     = v_s[NUM_W] && !full;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NUM_W; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < NUM_W; k++)
				v_s[k+1] <= v_s[k];
		end
	end

	// load numerator with half the divisor for round half up, then divide
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s[0].n <= (NUM_W'(px) << (FRAC_BITS + 1)) + NUM_W'(den_x >> 1);
			dx_s[0].r <= '0;
			dx_s[0].q <= '0;
			dy_s[0].n <= (NUM_W'(py) << (FRAC_BITS + 1)) + NUM_W'(den_y >> 1);
			dy_s[0].r <= '0;
			dy_s[0].q <= '0;
			for (int k = 0; k < NUM_W; k++) begin
				dx_s[k+1] <= div_step(dx_s[k], den_x);
				dy_s[k+1] <= div_step(dy_s[k], den_y);
			end
		end
	end

	// phi phase is 2u - 2.0, theta phase is v - 1.0, both on a circle of 4.0
	assign push_data.ph_phi = {dx_s[NUM_W].q[PH_W-2:0], 1'b0}
		- PH_W'(2 ** (FRAC_BITS + 1));
	assign push_data.ph_theta = dy_s[NUM_W].q - PH_W'(2 ** FRAC_BITS);

endmodule

### hdl/eqr_fifo.sv
// Short queue of phase pairs between the front and back parts.
module eqr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  eqr_pkg::phase_t  push_data,
	output logic             full,
	input  logic             pop,
	output eqr_pkg::phase_t  pop_data,
	output logic             not_empty
);
	import eqr_pkg::*;
	`include "assert_macros.svh"

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	phase_t           mem_q [0:FIFO_DEPTH-1];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`ASSERT_CLK(a_no_push_full, clk, arst_n, push |-> !full)
	`ASSERT_CLK(a_no_pop_empty, clk, arst_n, pop |-> not_empty)
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(FIFO_DEPTH))
	`ASSERT_CLK(a_count_up, clk, arst_n, (push && !pop) |=> count_q == $past(count_q) + 1'b1)

endmodule

### hdl/eqr_back.sv
// Back part: sine and cosine of both angles and the basis vector blend.
module eqr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         pop,
	input  eqr_pkg::phase_t              in_data,
	input  logic [eqr_pkg::AXIS_W-1:0]   axis_forward,
	input  logic [eqr_pkg::AXIS_W-1:0]   axis_right,
	input  logic [eqr_pkg::AXIS_W-1:0]   axis_up,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [eqr_pkg::COMP_W-1:0]   dir_x,
	output logic [eqr_pkg::COMP_W-1:0]   dir_y,
	output logic [eqr_pkg::COMP_W-1:0]   dir_z
);
	import eqr_pkg::*;

	localparam int NST  = 11;
	localparam int P1_W = SIN_W + COMP_W;
	localparam int H_W  = P1_W + 1;
	localparam int HR_W = H_W - FRAC_BITS;
	localparam int P2_W = SIN_W + HR_W;
	localparam int D_W  = P2_W + 1;
	localparam int M_W  = X_W + T_W;
	// lanes: sin phi, cos phi, sin theta, cos theta
	localparam int L_SP = 0;
	localparam int L_CP = 1;
	localparam int L_ST = 2;
	localparam int L_CT = 3;

	// c - (x2 * t) >> 30
	function automatic logic [T_W-1:0] poly_step(input logic [X_W-1:0] x2,
			input logic [T_W-1:0] t, input logic [T_W-1:0] c);
		logic [M_W-1:0] pr;
		pr = M_W'(x2) * M_W'(t);
		return c - T_W'(pr >> Q);
	endfunction

	function automatic logic signed [COMP_W-1:0] comp(input logic [AXIS_W-1:0] r,
			input int i);
		return r[COMP_W*i +: COMP_W];
	endfunction

	logic                    en;
	logic                    v_s [1:NST];
	logic [PH_W-1:0]         ph [0:3];
	logic [FRAC_BITS:0]      a_s1 [0:3];
	logic                    neg_s1 [0:3];
	logic [X_W-1:0]          x_s2 [0:3], x_s3 [0:3], x_s4 [0:3], x_s5 [0:3], x_s6 [0:3];
	logic [X_W-1:0]          x2_s2 [0:3], x2_s3 [0:3], x2_s4 [0:3], x2_s5 [0:3];
	logic                    neg_s2 [0:3], neg_s3 [0:3], neg_s4 [0:3], neg_s5 [0:3];
	logic                    neg_s6 [0:3];
	logic [T_W-1:0]          t_s3 [0:3], t_s4 [0:3], t_s5 [0:3], t_s6 [0:3];
	logic signed [SIN_W-1:0] sin_s7 [0:3];
	logic signed [SIN_W-1:0] st_s8, ct_s8, st_s9, ct_s9;
	logic signed [P1_W-1:0]  pf_s8 [0:2], pr_s8 [0:2];
	logic signed [HR_W-1:0]  hr_s9 [0:2];
	logic signed [P2_W-1:0]  pt_s10 [0:2], pu_s10 [0:2];
	logic signed [COMP_W-1:0] d_s11 [0:2];

	assign en        = !v_s[NST] || out_ready;
	assign pop       = in_valid && en;
	assign out_valid = v_s[NST];
	assign dir_x     = d_s11[0];
	assign dir_y     = d_s11[1];
	assign dir_z     = d_s11[2];

	// four phases, cosine as sine a quarter turn ahead
	assign ph[L_SP] = in_data.ph_phi;
	assign ph[L_CP] = in_data.ph_phi + PH_W'(2 ** FRAC_BITS);
	assign ph[L_ST] = in_data.ph_theta;
	assign ph[L_CT] = in_data.ph_theta + PH_W'(2 ** FRAC_BITS);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= pop;
			for (int k = 1; k < NST; k++)
				v_s[k+1] <= v_s[k];
		end
	end

	// sine lanes: fold to one quadrant, then Horner polynomial
	always_ff @(posedge clk) begin
		logic [M_W-1:0]     pr;
		logic [S_W-1:0]     s;
		logic [FRAC_BITS:0] rs;
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				a_s1[l] <= ph[l][FRAC_BITS] ?
					(FRAC_BITS+1)'(2 ** FRAC_BITS) - (FRAC_BITS+1)'(ph[l][FRAC_BITS-1:0]) :
					(FRAC_BITS+1)'(ph[l][FRAC_BITS-1:0]);
				neg_s1[l] <= ph[l][FRAC_BITS+1];

				x_s2[l]   <= X_W'(a_s1[l]) << SIN_SH;
				pr         = M_W'(X_W'(a_s1[l]) << SIN_SH) * M_W'(X_W'(a_s1[l]) << SIN_SH);
				x2_s2[l]  <= X_W'(pr >> Q);
				neg_s2[l] <= neg_s1[l];

				t_s3[l]   <= poly_step(x2_s2[l], SIN_C9, SIN_C7);
				x_s3[l]   <= x_s2[l];
				x2_s3[l]  <= x2_s2[l];
				neg_s3[l] <= neg_s2[l];

				t_s4[l]   <= poly_step(x2_s3[l], t_s3[l], SIN_C5);
				x_s4[l]   <= x_s3[l];
				x2_s4[l]  <= x2_s3[l];
				neg_s4[l] <= neg_s3[l];

				t_s5[l]   <= poly_step(x2_s4[l], t_s4[l], SIN_C3);
				x_s5[l]   <= x_s4[l];
				x2_s5[l]  <= x2_s4[l];
				neg_s5[l] <= neg_s4[l];

				t_s6[l]   <= poly_step(x2_s5[l], t_s5[l], SIN_C1);
				x_s6[l]   <= x_s5[l];
				neg_s6[l] <= neg_s5[l];

				// final product, cap at 1.0, round to output precision, sign
				pr = M_W'(x_s6[l]) * M_W'(t_s6[l]);
				s  = S_W'(pr >> Q);
				if (s > S_W'(2 ** Q))
					s = S_W'(2 ** Q);
				rs = (FRAC_BITS+1)'((s + S_W'(2 ** (SIN_SH - 1))) >> SIN_SH);
				sin_s7[l] <= neg_s6[l] ? -$signed(SIN_W'(rs)) : $signed(SIN_W'(rs));
			end
		end
	end

	// horizontal blend cos(phi)*F + sin(phi)*R, then vertical blend
	always_ff @(posedge clk) begin
		logic signed [P1_W-1:0] ma, mb;
		logic signed [H_W-1:0]  h;
		logic signed [P2_W-1:0] na, nb;
		logic signed [D_W-1:0]  d;
		if (en) begin
			st_s8 <= sin_s7[L_ST];
			ct_s8 <= sin_s7[L_CT];
			st_s9 <= st_s8;
			ct_s9 <= ct_s8;
			for (int i = 0; i < 3; i++) begin
				ma = P1_W'(sin_s7[L_CP]);
				mb = P1_W'(comp(axis_forward, i));
				pf_s8[i] <= ma * mb;
				ma = P1_W'(sin_s7[L_SP]);
				mb = P1_W'(comp(axis_right, i));
				pr_s8[i] <= ma * mb;

				h = H_W'(pf_s8[i]) + H_W'(pr_s8[i]) + H_W'(2 ** (FRAC_BITS - 1));
				hr_s9[i] <= HR_W'(h >>> FRAC_BITS);

				na = P2_W'(ct_s9);
				nb = P2_W'(hr_s9[i]);
				pt_s10[i] <= na * nb;
				na = P2_W'(st_s9);
				nb = P2_W'(comp(axis_up, i));
				pu_s10[i] <= na * nb;

				d = D_W'(pt_s10[i]) + D_W'(pu_s10[i]) + D_W'(2 ** (FRAC_BITS - 1));
				d = d >>> FRAC_BITS;
				if (d > D_W'(2 ** FRAC_BITS))
					d = D_W'(2 ** FRAC_BITS);
				if (d < -D_W'(2 ** FRAC_BITS))
					d = -D_W'(2 ** FRAC_BITS);
				d_s11[i] <= COMP_W'(d);
			end
		end
	end

endmodule

### hdl/equirect_pixel_to_ray_dir_top.sv
// Top level of the equirectangular pixel to ray direction block.
// Takes one pixel position per clock and returns one unit ray direction per
// position, in order, at a sustained rate of one transaction per cycle while
// the output is not stalled. The pipeline is a 35-stage front (a load stage,
// then one restoring divider step per stage over the 34-bit numerator, with
// both axes side by side), the 4-entry queue, and an
// 11-stage back end (quadrant fold, six Q30 multiplies of the sine
// polynomial, two multiply-and-round steps of the basis blend). The queue
// lets the front keep taking pixels after the output stalls, until it is full.
// Write the configuration registers only while no transaction is in flight.
module equirect_pixel_to_ray_dir_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [39:0]                 s_axis_tdata,   // pixel_x, pixel_y, zero pad
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [47:0]                 m_axis_tdata,   // dir_x, dir_y, dir_z
	input  logic                        cfg_we,
	input  logic [eqr_pkg::ADDR_W-1:0]  cfg_addr,
	input  logic [eqr_pkg::CFG_W-1:0]   cfg_wdata
);
	import eqr_pkg::*;

	logic [CFG_RES_W-1:0] res_width_q, res_height_q;
	logic [AXIS_W-1:0]    axis_forward_q, axis_right_q, axis_up_q;
	logic [RES_W-1:0]     res_w, res_h;
	logic                 push, full, pop, not_empty;
	phase_t               push_data, pop_data;
	logic [COMP_W-1:0]    dir_x, dir_y, dir_z;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_width_q    <= CFG_RES_W'(1920);
			res_height_q   <= CFG_RES_W'(1080);
			axis_forward_q <= AXIS_W'(48'd16384);
			axis_right_q   <= AXIS_W'(48'd1073741824);
			axis_up_q      <= AXIS_W'(48'd70368744177664);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RES_WIDTH:    res_width_q    <= cfg_wdata[CFG_RES_W-1:0];
				REG_RES_HEIGHT:   res_height_q   <= cfg_wdata[CFG_RES_W-1:0];
				REG_AXIS_FORWARD: axis_forward_q <= cfg_wdata[AXIS_W-1:0];
				REG_AXIS_RIGHT:   axis_right_q   <= cfg_wdata[AXIS_W-1:0];
				REG_AXIS_UP:      axis_up_q      <= cfg_wdata[AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	assign res_w = clamp_res(res_width_q);
	assign res_h = clamp_res(res_height_q);

	eqr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.px        (s_axis_tdata[PIX_W-1:0]),
		.py        (s_axis_tdata[2*PIX_W-1:PIX_W]),
		.res_w     (res_w),
		.res_h     (res_h),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	eqr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	eqr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (not_empty),
		.pop          (pop),
		.in_data      (pop_data),
		.axis_forward (axis_forward_q),
		.axis_right   (axis_right_q),
		.axis_up      (axis_up_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z)
	);

	assign m_axis_tdata = {dir_z, dir_y, dir_x};

endmodule

### sim/tb.sv
// Testbench for the equirectangular pixel to ray direction block.
module tb;
	import eqr_pkg::*;

	typedef struct packed {
		logic [17:0] py;
		logic [17:0] px;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} ray_t;

	localparam longint ONE_Q = 64'd1 << FRAC_BITS;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic cfg_we;
	logic [ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	// predictor copy of the configuration registers
	logic [13:0] cur_width, cur_height;
	logic [47:0] cur_fwd, cur_right, cur_up;

	pixel_t pending_pixels[$];
	ray_t expected_rays[$];
	int n_errors = 0;
	int n_rays = 0;
	int n_cfg = 0;
	bit send_gaps = 1;
	bit recv_gaps = 1;
	int hold_off = 0;

	equirect_pixel_to_ray_dir_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// round half up on an arithmetic right shift
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// sine over one quadrant, Q30 Horner polynomial
	function automatic longint quadrant_sine(longint a);
		longint unsigned x, x2, t, s;
		x = a << (30 - FRAC_BITS);
		x2 = (x * x) >> 30;
		t = SIN_C9;
		t = SIN_C7 - ((x2 * t) >> 30);
		t = SIN_C5 - ((x2 * t) >> 30);
		t = SIN_C3 - ((x2 * t) >> 30);
		t = SIN_C1 - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		if (s > 64'd1073741824)
			s = 64'd1073741824;
		s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		return longint'(s);
	endfunction

	function automatic longint phase_sine(longint unsigned ph);
		int q;
		longint r, s;
		q = int'((ph >> FRAC_BITS) & 3);
		r = ph & (ONE_Q - 1);
		s = q[0] ? quadrant_sine(ONE_Q - r) : quadrant_sine(r);
		return q[1] ? -s : s;
	endfunction

	function automatic longint unsigned unit_pos(longint unsigned p, logic [13:0] res);
		longint unsigned r, den;
		r = (res == 0) ? 1 : (res > MAX_RES) ? MAX_RES : res;
		den = r << PIXEL_FRAC_BITS;
		return ((p << (FRAC_BITS + 1)) + (den >> 1)) / den;
	endfunction

	function automatic longint comp(logic [47:0] v, int i);
		return longint'($signed(v[16*i +: 16]));
	endfunction

	function automatic ray_t ray_direction(pixel_t p);
		longint unsigned mask, ph_phi, ph_th;
		longint sp, cp, st, ct, h, d;
		ray_t r;
		mask = (64'd1 << (FRAC_BITS + 2)) - 1;
		ph_phi = (2 * unit_pos(p.px, cur_width) - 2 * ONE_Q) & mask;
		ph_th = (unit_pos(p.py, cur_height) - ONE_Q) & mask;
		sp = phase_sine(ph_phi);
		cp = phase_sine((ph_phi + ONE_Q) & mask);
		st = phase_sine(ph_th);
		ct = phase_sine((ph_th + ONE_Q) & mask);
		for (int i = 0; i < 3; i++) begin
			h = round_shift(cp * comp(cur_fwd, i) + sp * comp(cur_right, i), FRAC_BITS);
			d = round_shift(ct * h + st * comp(cur_up, i), FRAC_BITS);
			if (d > ONE_Q)
				d = ONE_Q;
			if (d < -ONE_Q)
				d = -ONE_Q;
			r[16*i +: 16] = d[15:0];
		end
		return r;
	endfunction

	// driver: offer pending pixels, with random gap bursts
	int send_idle = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				expected_rays.push_back(ray_direction(pixel_t'(s_axis_tdata[35:0])));
			if (send_idle > 0) begin
				send_idle <= send_idle - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				s_axis_tdata <= {4'd0, pending_pixels.pop_front()};
				s_axis_tvalid <= 1'b1;
				if (send_gaps && $urandom_range(0, 5) == 0)
					send_idle <= $urandom_range(1, 17);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	int recv_idle = 0;
	always @(posedge clk or negedge arst_n) begin
		ray_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				n_rays <= n_rays + 1;
				if (expected_rays.size() == 0) begin
					$error("unexpected ray %h", got);
					n_errors++;
				end else begin
					want = expected_rays.pop_front();
					if (got.x !== want.x) begin
						$error("dir_x expected %0d got %0d", want.x, got.x);
						n_errors++;
					end
					if (got.y !== want.y) begin
						$error("dir_y expected %0d got %0d", want.y, got.y);
						n_errors++;
					end
					if (got.z !== want.z) begin
						$error("dir_z expected %0d got %0d", want.z, got.z);
						n_errors++;
					end
				end
			end
			// hold off first, then random stall bursts
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_idle > 0) begin
				recv_idle <= recv_idle - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (recv_gaps && $urandom_range(0, 5) == 0)
					recv_idle <= $urandom_range(1, 17);
			end
		end
	end

	task automatic write_reg(logic [ADDR_W-1:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
		case (idx)
			REG_RES_WIDTH: cur_width = val[13:0];
			REG_RES_HEIGHT: cur_height = val[13:0];
			REG_AXIS_FORWARD: cur_fwd = val;
			REG_AXIS_RIGHT: cur_right = val;
			REG_AXIS_UP: cur_up = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_pixels.size() > 0 || s_axis_tvalid || expected_rays.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [17:0] rand_pos(logic [13:0] res);
		int unsigned lim;
		lim = ((res == 0) ? 1 : res) * 16;
		case ($urandom_range(0, 9))
			0: return 18'($urandom_range(0, 18'h3ffff));
			1: return 18'(lim);
			2: return 18'd0;
			default: return 18'($urandom_range(0, lim - 1));
		endcase
	endfunction

	function automatic logic [47:0] rand_axis();
		logic [47:0] v;
		for (int i = 0; i < 3; i++)
			case ($urandom_range(0, 4))
				0: v[16*i +: 16] = 16'd16384;
				1: v[16*i +: 16] = -16'sd16384;
				2: v[16*i +: 16] = 16'd0;
				3: v[16*i +: 16] = 16'($urandom_range(0, 16'hffff));
				default: v[16*i +: 16] = 16'($urandom_range(0, 23170) - 11585);
			endcase
		return v;
	endfunction

	task automatic random_pixels(int n);
		pixel_t p;
		repeat (n) begin
			p.px = rand_pos(cur_width);
			p.py = rand_pos(cur_height);
			pending_pixels.push_back(p);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cur_width = 14'd1920;
		cur_height = 14'd1080;
		cur_fwd = 48'd16384;
		cur_right = 48'd1073741824;
		cur_up = 48'd70368744177664;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, center, field extremes at reset settings
		pending_pixels.push_back('{py: 0, px: 0});
		pending_pixels.push_back('{py: 18'h3ffff, px: 18'h3ffff});
		pending_pixels.push_back('{py: 1080 * 8, px: 1920 * 8});
		pending_pixels.push_back('{py: 1080 * 16, px: 1920 * 16});
		pending_pixels.push_back('{py: 0, px: 1920 * 16});
		pending_pixels.push_back('{py: 1080 * 16, px: 0});
		pending_pixels.push_back('{py: 18'h2aaaa, px: 18'h15555});
		pending_pixels.push_back('{py: 18'h15555, px: 18'h2aaaa});
		pending_pixels.push_back('{py: 1080 * 4, px: 1920 * 12});
		drain();

		// zero and oversized resolution, unknown indexes, non-unit basis
		write_reg(REG_RES_WIDTH, 48'd0);
		write_reg(REG_RES_HEIGHT, 48'h3fff);
		write_reg(3'd7, 48'hffff_ffff_ffff);
		write_reg(3'd5, 48'h1234);
		write_reg(REG_AXIS_FORWARD, {16'h7fff, 16'h7fff, 16'h7fff});
		write_reg(REG_AXIS_RIGHT, {16'h8000, 16'h8000, 16'h8000});
		write_reg(REG_AXIS_UP, 48'hffff_ffff_ffff);
		pending_pixels.push_back('{py: 0, px: 0});
		pending_pixels.push_back('{py: 8192 * 8, px: 8});
		pending_pixels.push_back('{py: 18'h3ffff, px: 18'h3ffff});
		pending_pixels.push_back('{py: 8192 * 16, px: 16});
		pending_pixels.push_back('{py: 8192 * 4, px: 4});
		pending_pixels.push_back('{py: 12345, px: 3});
		drain();

		// long receiver hold-off so the block fills and stalls its input
		hold_off = 300;
		random_pixels(60);
		drain();

		// random phases across several settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_RES_WIDTH, (ph == 1) ? 48'd1 : (ph == 2) ? 48'd8192 :
				$urandom_range(1, 9000));
			write_reg(REG_RES_HEIGHT, (ph == 1) ? 48'd8192 : (ph == 2) ? 48'd1 :
				$urandom_range(0, 16383));
			write_reg(REG_AXIS_FORWARD, rand_axis());
			write_reg(REG_AXIS_RIGHT, rand_axis());
			write_reg(REG_AXIS_UP, rand_axis());
			if (ph == 5) begin
				send_gaps = 0;
				recv_gaps = 0;
			end
			random_pixels(130);
			drain();
		end

		$display("tb: %0d rays checked over %0d register writes,", n_rays, n_cfg);
		$display("tb: including resolution extremes, wrapped angles and saturation");
		if (n_errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule
